FILE: src/cpu8ls_pkg.sv
// Shared types and constants for the 8-bit load/store/ADC execute slice.
// No dependencies; used by the ALU and the top level.
`default_nettype none

package cpu8ls_pkg;

    typedef enum logic [3:0] {
        OP_ADC = 4'd0,
        OP_AND = 4'd1,
        OP_LDA = 4'd2,
        OP_LDX = 4'd3,
        OP_LDY = 4'd4,
        OP_SBC = 4'd5,
        OP_STA = 4'd6,
        OP_STX = 4'd7,
        OP_STY = 4'd8,
        OP_TAX = 4'd9
    } op_t;

    // status byte bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam int SIGN_BIT = 7;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] flags;
    } arch_state_t;

    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_data;
    } store_t;

endpackage

`default_nettype wire

FILE: src/cpu8ls_alu.sv
// Combinational execute unit: one instruction against the current register file.
// Depends on cpu8ls_pkg.
`default_nettype none

module cpu8ls_alu (
    input  wire logic [3:0]             op,
    input  wire logic [7:0]             operand,
    input  wire cpu8ls_pkg::arch_state_t cur,
    output cpu8ls_pkg::arch_state_t      nxt,
    output cpu8ls_pkg::store_t           store
);

    logic [7:0] addend;
    logic [8:0] sum;
    logic       ovf;

    // sbc is adc of the inverted operand
    assign addend = (cpu8ls_pkg::op_t'(op) == cpu8ls_pkg::OP_SBC) ? ~operand : operand;
    assign sum    = {1'b0, cur.acc} + {1'b0, addend}
                  + {8'd0, cur.flags[cpu8ls_pkg::FLAG_C]};
    assign ovf    = ~(cur.acc[cpu8ls_pkg::SIGN_BIT] ^ addend[cpu8ls_pkg::SIGN_BIT])
                  & (cur.acc[cpu8ls_pkg::SIGN_BIT] ^ sum[cpu8ls_pkg::SIGN_BIT]);

    always_comb
    begin
        logic [7:0] res;
        logic       set_zn;
        res               = 8'd0;
        set_zn            = 1'b0;
        nxt               = cur;
        store.store_valid = 1'b0;
        store.store_data  = 8'd0;
        case (cpu8ls_pkg::op_t'(op))
            cpu8ls_pkg::OP_ADC,
            cpu8ls_pkg::OP_SBC:
            begin
                res                             = sum[7:0];
                nxt.acc                         = res;
                nxt.flags[cpu8ls_pkg::FLAG_C]   = sum[8];
                nxt.flags[cpu8ls_pkg::FLAG_V]   = ovf;
                set_zn                          = 1'b1;
            end
            cpu8ls_pkg::OP_AND:
            begin
                res     = cur.acc & operand;
                nxt.acc = res;
                set_zn  = 1'b1;
            end
            cpu8ls_pkg::OP_LDA:
            begin
                res     = operand;
                nxt.acc = res;
                set_zn  = 1'b1;
            end
            cpu8ls_pkg::OP_LDX:
            begin
                res    = operand;
                nxt.x  = res;
                set_zn = 1'b1;
            end
            cpu8ls_pkg::OP_LDY:
            begin
                res    = operand;
                nxt.y  = res;
                set_zn = 1'b1;
            end
            cpu8ls_pkg::OP_TAX:
            begin
                res    = cur.acc;
                nxt.x  = res;
                set_zn = 1'b1;
            end
            cpu8ls_pkg::OP_STA:
            begin
                store.store_valid = 1'b1;
                store.store_data  = cur.acc;
            end
            cpu8ls_pkg::OP_STX:
            begin
                store.store_valid = 1'b1;
                store.store_data  = cur.x;
            end
            cpu8ls_pkg::OP_STY:
            begin
                store.store_valid = 1'b1;
                store.store_data  = cur.y;
            end
            default:
            begin
                // unused opcodes leave everything alone
            end
        endcase
        if (set_zn)
        begin
            nxt.flags[cpu8ls_pkg::FLAG_Z] = (res == 8'd0);
            nxt.flags[cpu8ls_pkg::FLAG_N] = res[cpu8ls_pkg::SIGN_BIT];
        end
    end

endmodule

`default_nettype wire

FILE: src/cpu8_load_store_adc_execute_core.sv
// Top level of the execute slice: input register, ALU, register file, result register.
// Depends on cpu8ls_pkg and cpu8ls_alu.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | op, operand
//  out     | out_valid / out_stall| store_valid, store_data, acc_out, x_out, y_out,
//          |                      | flags_out
//
// One instruction per cycle sustained while out is not stalled. out_valid rises once a
// taken word has passed the input register and then the result register; these two
// registers around the single ALU pass lie between a word's acceptance and its result.
// The register file updates when an instruction moves into the result register, so the
// next instruction always sees the state its predecessor left.
// Reset clears A, X, Y, status and both valid bits.
// A stall on out holds the result; in stalls when both registers are full and out stalls.
`default_nettype none

module cpu8_load_store_adc_execute_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [3:0] op,
    input  wire logic [7:0] operand,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            store_valid,
    output logic [7:0]      store_data,
    output logic [7:0]      acc_out,
    output logic [7:0]      x_out,
    output logic [7:0]      y_out,
    output logic [7:0]      flags_out
);

    logic                    s1_valid_reg;
    logic [3:0]              op_reg;
    logic [7:0]              operand_reg;
    logic                    out_valid_reg;
    cpu8ls_pkg::store_t      store_reg;
    cpu8ls_pkg::store_t      store_next;
    cpu8ls_pkg::arch_state_t state_reg;
    cpu8ls_pkg::arch_state_t state_next;
    logic                    advance;
    logic                    in_take;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    cpu8ls_alu u_alu (
        .op      (op_reg),
        .operand (operand_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .store   (store_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg      <= op;
            operand_reg <= operand;
        end
        if (advance)
            store_reg <= store_next;
    end

    assign out_valid   = out_valid_reg;
    assign store_valid = store_reg.store_valid;
    assign store_data  = store_reg.store_data;
    // the register file only moves when a new result is loaded, so it is the result
    assign acc_out     = state_reg.acc;
    assign x_out       = state_reg.x;
    assign y_out       = state_reg.y;
    assign flags_out   = state_reg.flags;

endmodule

`default_nettype wire

FILE: src/cpu8ls_checker.sv
// Port-level checks for the execute slice, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module cpu8ls_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [3:0] op,
    input wire logic [7:0] operand,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       store_valid,
    input wire logic [7:0] store_data,
    input wire logic [7:0] acc_out,
    input wire logic [7:0] x_out,
    input wire logic [7:0] y_out,
    input wire logic [7:0] flags_out
);

    // held result must not move
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(store_valid) && $stable(store_data)
            && $stable(acc_out) && $stable(x_out) && $stable(y_out) && $stable(flags_out))
        else $error("result changed while stalled");

    a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !store_valid |-> store_data == 8'd0)
        else $error("store_data nonzero without store");

    a_flags_unused: assert property (@(posedge clk) disable iff (!rst_n)
        flags_out[5:2] == 4'd0)
        else $error("unused status bits set");

    // registers only change when a fresh result is loaded
    a_state_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !($stable(acc_out) && $stable(x_out) && $stable(y_out) && $stable(flags_out))
            |-> out_valid)
        else $error("register file changed without a result");

endmodule

bind cpu8_load_store_adc_execute_core cpu8ls_checker u_cpu8ls_checker (.*);

`default_nettype wire
